// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication from one cycle to the next
`define ASSERT_NEXT(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

// ===== hw/rtl/tlc_pkg.sv =====
`timescale 1ns / 1ps
package tlc_pkg;

   localparam int FIRST_SETS   = 64;
   localparam int FIRST_WAYS   = 4;
   localparam int SECOND_SETS  = 256;
   localparam int SECOND_WAYS  = 8;
   localparam int ADDRESS_BITS = 32;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_BLOCK_BITS     = 3'd0,
      REG_L1_SET_BITS    = 3'd1,
      REG_L1_WAY_BITS    = 3'd2,
      REG_L2_SET_BITS    = 3'd3,
      REG_L2_WAY_BITS    = 3'd4,
      REG_WRITE_ALLOCATE = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_TOUCH = 2'd1,
      CMD_FILL  = 2'd2,
      CMD_DROP  = 2'd3
   } level_cmd_type;

   // largest s with 2^s <= v, v >= 1
   function automatic int floor_log2(input int v);
      int s;
      s = 0;
      while ((s < 20) && ((2 << s) <= v)) s++;
      return s;
   endfunction

endpackage

// ===== hw/rtl/tlc_level.sv =====
`timescale 1ns / 1ps
module tlc_level #(
   parameter int SETS      = tlc_pkg::FIRST_SETS,
   parameter int WAYS      = tlc_pkg::FIRST_WAYS,
   parameter int ADDR_BITS = tlc_pkg::ADDRESS_BITS,
   localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1,
   localparam int FILL_W   = $clog2(WAYS + 1)
) (
   input  logic                   clock,
   input  logic [SET_W-1:0]       rd_set,
   input  tlc_pkg::level_cmd_type cmd,
   input  logic [ADDR_BITS-1:0]   blk,
   input  logic [FILL_W-1:0]      way_limit,
   input  logic                   clr_en,
   input  logic [SET_W-1:0]       clr_set,
   output logic                   hit,
   output logic                   evict,
   output logic [ADDR_BITS-1:0]   victim
);

   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef struct packed {
      logic                 valid;
      logic [RANK_W-1:0]    rank;
      logic [ADDR_BITS-1:0] blk;
   } entry_type;

   typedef struct packed {
      logic [FILL_W-1:0]      fill;
      entry_type [WAYS-1:0]   way;
   } row_type;

   row_type          mem [SETS];
   row_type          row_ff;
   logic [SET_W-1:0] set_ff;
   row_type          row_in;
   logic [WAYS-1:0]  match;
   logic [RANK_W-1:0] hit_idx;

   function automatic row_type make_mru(input row_type r, input logic [RANK_W-1:0] s);
      row_type           o;
      logic [RANK_W-1:0] rk;
      o  = r;
      rk = r.way[s].rank;
      for (int i = 0; i < WAYS; i++) begin
         if ((FILL_W'(i) < r.fill) && (r.way[i].rank < rk)) begin
            o.way[i].rank = r.way[i].rank + RANK_W'(1);
         end
      end
      o.way[s].rank = '0;
      return o;
   endfunction

   always_comb begin
      logic              found;
      logic [RANK_W-1:0] pick;
      logic [RANK_W-1:0] best;
      row_in  = row_ff;
      evict   = 1'b0;
      victim  = row_ff.way[0].blk;
      found   = 1'b0;
      pick    = '0;
      best    = '0;
      hit_idx = '0;
      for (int i = 0; i < WAYS; i++) begin
         match[i] = (FILL_W'(i) < row_ff.fill) && row_ff.way[i].valid &&
                    (row_ff.way[i].blk == blk);
      end
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (match[i]) hit_idx = RANK_W'(i);
      end
      hit = |match;
      unique case (cmd)
         tlc_pkg::CMD_TOUCH: begin
            if (hit) row_in = make_mru(row_ff, hit_idx);
         end
         tlc_pkg::CMD_DROP: begin
            for (int i = 0; i < WAYS; i++) begin
               if (match[i]) row_in.way[i].valid = 1'b0;
            end
         end
         tlc_pkg::CMD_FILL: begin
            // reuse the invalidated slot nearest MRU
            for (int i = 0; i < WAYS; i++) begin
               if ((FILL_W'(i) < row_ff.fill) && !row_ff.way[i].valid &&
                   (!found || (row_ff.way[i].rank < best))) begin
                  found = 1'b1;
                  pick  = RANK_W'(i);
                  best  = row_ff.way[i].rank;
               end
            end
            if (found) begin
               row_in = make_mru(row_ff, pick);
               row_in.way[pick].blk   = blk;
               row_in.way[pick].valid = 1'b1;
            end else if (row_ff.fill < way_limit) begin
               for (int i = 0; i < WAYS; i++) begin
                  if (FILL_W'(i) < row_ff.fill) begin
                     row_in.way[i].rank = row_ff.way[i].rank + RANK_W'(1);
                  end
               end
               row_in.way[row_ff.fill[RANK_W-1:0]].rank  = '0;
               row_in.way[row_ff.fill[RANK_W-1:0]].blk   = blk;
               row_in.way[row_ff.fill[RANK_W-1:0]].valid = 1'b1;
               row_in.fill = row_ff.fill + FILL_W'(1);
            end else begin
               for (int i = 0; i < WAYS; i++) begin
                  if ((FILL_W'(i) < row_ff.fill) &&
                      (row_ff.way[i].rank == RANK_W'(row_ff.fill - FILL_W'(1)))) begin
                     pick = RANK_W'(i);
                  end
               end
               evict  = 1'b1;
               victim = row_ff.way[pick].blk;
               row_in = make_mru(row_ff, pick);
               row_in.way[pick].blk   = blk;
               row_in.way[pick].valid = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff <= mem[rd_set];
      set_ff <= rd_set;
      if (clr_en) begin
         mem[clr_set] <= '0;
      end else if (cmd != tlc_pkg::CMD_NONE) begin
         mem[set_ff] <= row_in;
      end
   end

endmodule

// ===== hw/rtl/two_level_inclusive_lru_cache.sv =====
// Sequence from request transfer to response: an L1 hit, an L2 hit or a miss without eviction
//   passes ST_RD, ST_LOOK and ST_DONE; a victim touch adds ST_TOUCH_RD and ST_TOUCH, and an L2
//   miss that evicts in both levels also passes ST_DROP_RD, ST_DROP, ST_FILL1_RD and ST_FILL1.
// Accesses: one at a time; a new request is taken while the previous response still waits
//   on rsp_ready.
// Reset: synchronous, active high; then a clearing pass over max(FIRST_SETS, SECOND_SETS) sets
//   sweeps both tag memories, repeated after every register write.
`timescale 1ns / 1ps
module two_level_inclusive_lru_cache #(
   parameter int FIRST_SETS   = tlc_pkg::FIRST_SETS,
   parameter int FIRST_WAYS   = tlc_pkg::FIRST_WAYS,
   parameter int SECOND_SETS  = tlc_pkg::SECOND_SETS,
   parameter int SECOND_WAYS  = tlc_pkg::SECOND_WAYS,
   parameter int ADDRESS_BITS = tlc_pkg::ADDRESS_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [31:0]                    req_address,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_l1_hit,
   output logic                           rsp_l2_hit,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tlc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tlc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tlc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   `include "assert_macros.svh"

   localparam int SW1 = (FIRST_SETS > 1) ? $clog2(FIRST_SETS) : 1;
   localparam int SW2 = (SECOND_SETS > 1) ? $clog2(SECOND_SETS) : 1;
   localparam int FW1 = $clog2(FIRST_WAYS + 1);
   localparam int FW2 = $clog2(SECOND_WAYS + 1);
   localparam int MAX_SETS = (FIRST_SETS > SECOND_SETS) ? FIRST_SETS : SECOND_SETS;
   localparam int CNT_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int L1_SET_MAX = tlc_pkg::floor_log2(FIRST_SETS);
   localparam int L2_SET_MAX = tlc_pkg::floor_log2(SECOND_SETS);
   localparam int L1_WAY_MAX = tlc_pkg::floor_log2(FIRST_WAYS);
   localparam int L2_WAY_MAX = tlc_pkg::floor_log2(SECOND_WAYS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_LOOK, ST_DROP_RD, ST_DROP, ST_FILL1_RD, ST_FILL1,
      ST_TOUCH_RD, ST_TOUCH, ST_DONE
   } state_type;

   state_type state_ff;

   logic [3:0] block_bits_ff;
   logic [2:0] l1_set_bits_ff;
   logic [1:0] l1_way_bits_ff;
   logic [3:0] l2_set_bits_ff;
   logic [1:0] l2_way_bits_ff;
   logic       write_allocate_ff;

   logic                    clearing_ff;
   logic [CNT_W-1:0]        clr_cnt_ff;
   logic                    kind_ff;
   logic [ADDRESS_BITS-1:0] blk_ff;
   logic [ADDRESS_BITS-1:0] vic_ff;
   logic                    res_l1_ff;
   logic                    res_l2_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_l1_ff;
   logic                    rsp_l2_ff;

   logic                    csr_write;
   logic [2:0]              csr_index;
   logic [ADDRESS_BITS-1:0] addr_ext;
   logic [4:0]              sb1;
   logic [4:0]              sb2;
   logic [SW1-1:0]          mask1;
   logic [SW2-1:0]          mask2;
   logic [FW1-1:0]          lim1;
   logic [FW2-1:0]          lim2;
   logic [ADDRESS_BITS-1:0] l1_blk;
   logic [ADDRESS_BITS-1:0] l2_blk;
   logic [ADDRESS_BITS-1:0] l1_rd_blk;
   logic [ADDRESS_BITS-1:0] l2_rd_blk;
   tlc_pkg::level_cmd_type  l1_cmd;
   tlc_pkg::level_cmd_type  l2_cmd;
   logic                    l1_hit;
   logic                    l2_hit;
   logic                    l1_evict;
   logic                    l2_evict;
   logic [ADDRESS_BITS-1:0] l1_victim;
   logic [ADDRESS_BITS-1:0] l2_victim;
   logic                    allocate;
   logic                    l1_clr;
   logic                    l2_clr;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         tlc_pkg::REG_BLOCK_BITS:     csr_prdata = 32'(block_bits_ff);
         tlc_pkg::REG_L1_SET_BITS:    csr_prdata = 32'(l1_set_bits_ff);
         tlc_pkg::REG_L1_WAY_BITS:    csr_prdata = 32'(l1_way_bits_ff);
         tlc_pkg::REG_L2_SET_BITS:    csr_prdata = 32'(l2_set_bits_ff);
         tlc_pkg::REG_L2_WAY_BITS:    csr_prdata = 32'(l2_way_bits_ff);
         tlc_pkg::REG_WRITE_ALLOCATE: csr_prdata = 32'(write_allocate_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bits_ff     <= 4'd4;
         l1_set_bits_ff    <= 3'd4;
         l1_way_bits_ff    <= 2'd1;
         l2_set_bits_ff    <= 4'd6;
         l2_way_bits_ff    <= 2'd2;
         write_allocate_ff <= 1'b1;
         clearing_ff       <= 1'b1;
         clr_cnt_ff        <= '0;
      end else begin
         if (clearing_ff) begin
            clr_cnt_ff <= clr_cnt_ff + CNT_W'(1);
            if (clr_cnt_ff == CNT_W'(MAX_SETS - 1)) clearing_ff <= 1'b0;
         end
         if (csr_write) begin
            // any register write flushes both levels
            unique case (csr_index)
               tlc_pkg::REG_BLOCK_BITS:     block_bits_ff     <= csr_pwdata[3:0];
               tlc_pkg::REG_L1_SET_BITS:    l1_set_bits_ff    <= csr_pwdata[2:0];
               tlc_pkg::REG_L1_WAY_BITS:    l1_way_bits_ff    <= csr_pwdata[1:0];
               tlc_pkg::REG_L2_SET_BITS:    l2_set_bits_ff    <= csr_pwdata[3:0];
               tlc_pkg::REG_L2_WAY_BITS:    l2_way_bits_ff    <= csr_pwdata[1:0];
               tlc_pkg::REG_WRITE_ALLOCATE: write_allocate_ff <= csr_pwdata[0];
               default: ;
            endcase
            if (csr_index <= 3'(tlc_pkg::REG_WRITE_ALLOCATE)) begin
               clearing_ff <= 1'b1;
               clr_cnt_ff  <= '0;
            end
         end
      end
   end

   // geometry clamped to the storage
   assign sb1   = (int'(l1_set_bits_ff) > L1_SET_MAX) ? 5'(L1_SET_MAX) : 5'(l1_set_bits_ff);
   assign sb2   = (int'(l2_set_bits_ff) > L2_SET_MAX) ? 5'(L2_SET_MAX) : 5'(l2_set_bits_ff);
   assign mask1 = SW1'((64'(1) << sb1) - 64'(1));
   assign mask2 = SW2'((64'(1) << sb2) - 64'(1));
   assign lim1  = (int'(l1_way_bits_ff) > L1_WAY_MAX) ? FW1'(1 << L1_WAY_MAX)
                                                       : FW1'(1 << l1_way_bits_ff);
   assign lim2  = (int'(l2_way_bits_ff) > L2_WAY_MAX) ? FW2'(1 << L2_WAY_MAX)
                                                       : FW2'(1 << l2_way_bits_ff);

   assign addr_ext  = ADDRESS_BITS'(req_address);
   assign allocate  = !kind_ff || write_allocate_ff;
   assign l1_rd_blk = (state_ff == ST_DROP_RD) ? vic_ff : blk_ff;
   assign l2_rd_blk = (state_ff == ST_TOUCH_RD) ? vic_ff : blk_ff;
   assign l1_blk    = (state_ff == ST_DROP) ? vic_ff : blk_ff;
   assign l2_blk    = (state_ff == ST_TOUCH) ? vic_ff : blk_ff;
   assign l1_clr    = clearing_ff && (int'(clr_cnt_ff) < FIRST_SETS);
   assign l2_clr    = clearing_ff && (int'(clr_cnt_ff) < SECOND_SETS);

   always_comb begin
      l1_cmd = tlc_pkg::CMD_NONE;
      l2_cmd = tlc_pkg::CMD_NONE;
      unique case (state_ff)
         ST_LOOK: begin
            if (l1_hit) begin
               l1_cmd = tlc_pkg::CMD_TOUCH;
            end else if (l2_hit) begin
               l2_cmd = tlc_pkg::CMD_TOUCH;
               if (allocate) l1_cmd = tlc_pkg::CMD_FILL;
            end else if (allocate) begin
               l2_cmd = tlc_pkg::CMD_FILL;
               if (!l2_evict) l1_cmd = tlc_pkg::CMD_FILL;
            end
         end
         ST_DROP:  l1_cmd = tlc_pkg::CMD_DROP;
         ST_FILL1: l1_cmd = tlc_pkg::CMD_FILL;
         ST_TOUCH: l2_cmd = tlc_pkg::CMD_TOUCH;
         default: ;
      endcase
   end

   tlc_level #(
      .SETS(FIRST_SETS), .WAYS(FIRST_WAYS), .ADDR_BITS(ADDRESS_BITS)
   ) u_l1 (
      .clock(clock),
      .rd_set(l1_rd_blk[SW1-1:0] & mask1),
      .cmd(l1_cmd),
      .blk(l1_blk),
      .way_limit(lim1),
      .clr_en(l1_clr),
      .clr_set(clr_cnt_ff[SW1-1:0]),
      .hit(l1_hit),
      .evict(l1_evict),
      .victim(l1_victim)
   );

   tlc_level #(
      .SETS(SECOND_SETS), .WAYS(SECOND_WAYS), .ADDR_BITS(ADDRESS_BITS)
   ) u_l2 (
      .clock(clock),
      .rd_set(l2_rd_blk[SW2-1:0] & mask2),
      .cmd(l2_cmd),
      .blk(l2_blk),
      .way_limit(lim2),
      .clr_en(l2_clr),
      .clr_set(clr_cnt_ff[SW2-1:0]),
      .hit(l2_hit),
      .evict(l2_evict),
      .victim(l2_victim)
   );

   assign req_ready  = (state_ff == ST_IDLE) && !clearing_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_l1_hit = rsp_l1_ff;
   assign rsp_l2_hit = rsp_l2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  kind_ff  <= req_kind;
                  blk_ff   <= addr_ext >> block_bits_ff;
                  state_ff <= ST_RD;
               end
            end
            ST_RD: state_ff <= ST_LOOK;
            ST_LOOK: begin
               res_l1_ff <= l1_hit;
               res_l2_ff <= !l1_hit && l2_hit;
               state_ff  <= ST_DONE;
               if (!l1_hit && l2_hit && allocate && l1_evict) begin
                  vic_ff   <= l1_victim;
                  state_ff <= ST_TOUCH_RD;
               end else if (!l1_hit && !l2_hit && allocate) begin
                  if (l2_evict) begin
                     vic_ff   <= l2_victim;
                     state_ff <= ST_DROP_RD;
                  end else if (l1_evict) begin
                     vic_ff   <= l1_victim;
                     state_ff <= ST_TOUCH_RD;
                  end
               end
            end
            ST_DROP_RD:  state_ff <= ST_DROP;
            ST_DROP:     state_ff <= ST_FILL1_RD;
            ST_FILL1_RD: state_ff <= ST_FILL1;
            ST_FILL1: begin
               if (l1_evict) begin
                  vic_ff   <= l1_victim;
                  state_ff <= ST_TOUCH_RD;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_TOUCH_RD: state_ff <= ST_TOUCH;
            ST_TOUCH:    state_ff <= ST_DONE;
            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_l1_ff    <= res_l1_ff;
                  rsp_l2_ff    <= res_l2_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_CLK(a_hit_excl, clock, reset, rsp_valid_ff |-> !(rsp_l1_ff && rsp_l2_ff), "both hit flags set")
   `ASSERT_NEXT(a_idle_hold, clock, reset, (state_ff == ST_IDLE) && !(req_valid && req_ready), state_ff == ST_IDLE, "left idle without a transfer")
   `ASSERT_NEXT(a_flush, clock, reset, csr_write && (csr_index <= 3'(tlc_pkg::REG_WRITE_ALLOCATE)), clearing_ff && (clr_cnt_ff == '0), "register write did not restart clearing")

endmodule
